FILE: hw/rtl/sosc_pkg.sv
// Package: widths, reset values and sine table generator for the sine oscillator.
`timescale 1ns / 1ps

package sosc_pkg;

    localparam int FREQ_W         = 32;
    localparam int RATE_W         = 40;
    localparam int PHASE_W        = 32;
    localparam int SAMPLE_W       = 16;
    localparam int TABLE_BITS_DEF = 10;

    localparam logic [RATE_W-1:0] RATE_RESET = 40'd5864062015;

    // sin(pi/2 * t) Taylor coefficients, Q30 magnitudes
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] CO1     = 64'd1686629713;
    localparam logic [63:0] CO3     = 64'd693598668;
    localparam logic [63:0] CO5     = 64'd85569305;
    localparam logic [63:0] CO7     = 64'd5026995;
    localparam logic [63:0] CO9     = 64'd172271;

    // Sine of a full-cycle phase as a Q1.15 pattern; evaluated only at elaboration.
    function automatic logic [SAMPLE_W-1:0] phase_sine(input logic [PHASE_W-1:0] ph);
        logic [1:0]  quad;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] s;
        logic [31:0] mag;
        quad = ph[PHASE_W-1 -: 2];
        t    = {34'd0, ph[29:0]};
        if (quad[0]) begin
            t = ONE_Q30 - t;
        end
        t2 = (t * t) >> 30;
        p  = CO7 - ((t2 * CO9) >> 30);
        p  = CO5 - ((t2 * p) >> 30);
        p  = CO3 - ((t2 * p) >> 30);
        p  = CO1 - ((t2 * p) >> 30);
        s  = (t * p) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        mag = s[31:0];
        if (quad[1]) begin
            return SAMPLE_W'(32'd0 - mag);
        end
        return mag[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/sosc_if.sv
// Interfaces: frequency, sample and configuration channels with valid/ready.
`timescale 1ns / 1ps

interface sosc_freq_if import sosc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [FREQ_W-1:0] freq_hz;

    modport source (output valid, output freq_hz, input ready);
    modport sink   (input valid, input freq_hz, output ready);
endinterface

interface sosc_sample_if import sosc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sosc_cfg_if import sosc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate_reciprocal;

    modport source (output valid, output rate_reciprocal, input ready);
    modport sink   (input valid, input rate_reciprocal, output ready);
endinterface

FILE: hw/rtl/sosc_rom.sv
// Sine table ROM with a registered, enabled read port.
`timescale 1ns / 1ps

module sosc_rom import sosc_pkg::*; #(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [TABLE_BITS-1:0] i_addr,
    output logic [SAMPLE_W-1:0]   o_data
);

    localparam int DEPTH = 2 ** TABLE_BITS;

    logic [SAMPLE_W-1:0] w_rom [DEPTH];
    logic [SAMPLE_W-1:0] r_data;

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        assign w_rom[k] = phase_sine(PHASE_W'(k) << (PHASE_W - TABLE_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

FILE: hw/rtl/sine_oscillator.sv
// Top level: numerically controlled sine oscillator, one sample per transaction.
`timescale 1ns / 1ps

// Usage
//   i_freq   : one transaction per audio sample, freq_hz in Hz as signed Q16.16.
//   o_sample : one transaction per input, sine of the phase held before that
//              input, signed Q1.15, from a 2^TABLE_BITS entry table.
//   i_cfg    : writes rate_reciprocal (2^48 / sample rate). Always ready; write
//              only while no sample is in flight.
// Pipeline: input register, two partial products of freq x rate, increment
//   sum, then phase accumulate plus registered table read into the result
//   register. One transaction per cycle is sustained while o_sample is ready,
//   set by the single-add phase loop.
// Stall: each stage advances when it is empty or the stage after it advances,
//   so bubbles close up; with o_sample stalled the four stages fill and
//   i_freq.ready drops. Results are never lost or repeated.
// Reset: phase returns to zero, rate_reciprocal to the 48 kHz value, and the
//   pipeline empties. The sine table is constant and needs no fill.

module sine_oscillator import sosc_pkg::*; #(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sosc_freq_if.sink     i_freq,
    sosc_cfg_if.sink      i_cfg,
    sosc_sample_if.source o_sample
);

    localparam int LO_W   = RATE_W / 2;
    localparam int HI_W   = RATE_W - LO_W;
    localparam int PROD_W = FREQ_W + HI_W + 1;
    localparam int SUM_W  = 64;

    // stage valids: 0 input, 1 partial products, 2 increment, 3 result
    logic [3:0] r_valid;
    logic [3:0] n_valid;
    logic [3:0] w_load;

    logic [RATE_W-1:0]        r_rate;
    logic signed [FREQ_W-1:0] r_freq;
    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] n_p0;
    logic signed [PROD_W-1:0] n_p1;
    logic [PHASE_W-1:0]       r_inc;
    logic [SUM_W-1:0]         w_sum;
    logic [PHASE_W-1:0]       r_phase;
    logic                     w_step;
    logic [SAMPLE_W-1:0]      w_rom_data;

    // Advance a stage when it is empty or its contents move on.
    assign w_load[3] = !r_valid[3] || o_sample.ready;
    assign w_load[2] = !r_valid[2] || w_load[3];
    assign w_load[1] = !r_valid[1] || w_load[2];
    assign w_load[0] = !r_valid[0] || w_load[1];

    assign i_freq.ready = w_load[0];
    assign i_cfg.ready  = 1'b1;

    // An increment enters the accumulator exactly when its item enters the result stage.
    assign w_step = w_load[3] && r_valid[2];

    always_comb begin
        n_valid[0] = w_load[0] ? i_freq.valid : r_valid[0];
        n_valid[1] = w_load[1] ? r_valid[0]   : r_valid[1];
        n_valid[2] = w_load[2] ? r_valid[1]   : r_valid[2];
        n_valid[3] = w_load[3] ? r_valid[2]   : r_valid[3];
    end

    // Split the 40-bit rate so each product stays near 32 x 20 bits.
    always_comb begin
        n_p0 = r_freq * $signed({1'b0, r_rate[LO_W-1:0]});
        n_p1 = r_freq * $signed({1'b0, r_rate[RATE_W-1:LO_W]});
    end

    // Recombine; only bits 32..63 of the full product feed the phase.
    assign w_sum = SUM_W'(r_p0) + (SUM_W'(r_p1) << LO_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rate  <= RATE_RESET;
            r_phase <= '0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_rate <= i_cfg.rate_reciprocal;
            end
            if (w_step) begin
                r_phase <= r_phase + r_inc;
            end
        end
    end

    // Payload registers: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_freq <= i_freq.freq_hz;
        end
        if (w_load[1]) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
        end
        if (w_load[2]) begin
            r_inc <= w_sum[SUM_W-1 -: PHASE_W];
        end
    end

    // Read the table with the phase from before this item's increment.
    sosc_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_step),
        .i_addr (r_phase[PHASE_W-1 -: TABLE_BITS]),
        .o_data (w_rom_data)
    );

    assign o_sample.valid  = r_valid[3];
    assign o_sample.sample = w_rom_data;

`ifndef NO_ASSERTIONS
    // The phase moves only when an increment is retired into the result stage.
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_phase))
        else $error("phase changed without a retiring increment");

    // A zero rate register leaves the phase where it is.
    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_rate == '0 && !(i_cfg.valid && i_cfg.ready)) |=> $stable(r_phase))
        else $error("phase moved with zero rate");

    // Any empty stage must let a new input in.
    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid != 4'b1111) |-> i_freq.ready)
        else $error("input stalled with an empty stage");

    // A stalled result keeps its valid and its sample.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sample.valid && !o_sample.ready) |=> (o_sample.valid && $stable(o_sample.sample)))
        else $error("stalled result dropped or changed");
`endif

endmodule
